// ===== hw/rtl/qte_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle converter.
package qte_pkg;

  localparam int TERM_W   = 34;
  localparam int CORDIC_W = TERM_W + 2;
  localparam int ANG_W    = 18;
  localparam int ATAN_LEN = 30;
  localparam int RAD_W    = 62;
  localparam int ROOT_STEPS = 31;

  localparam logic signed [TERM_W-1:0] ONE_Q30 = TERM_W'(64'sd1 <<< 30);
  localparam logic signed [ANG_W-1:0]  PITCH_MAX = ANG_W'(18'sd16384);
  localparam logic signed [ANG_W-1:0]  PITCH_MIN = -ANG_W'(18'sd16384);

  localparam logic [31:0] ATAN_UNITS [0:ATAN_LEN-1] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } euler_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] sinr;
    logic signed [TERM_W-1:0] cosr;
    logic signed [TERM_W-1:0] siny;
    logic signed [TERM_W-1:0] cosy;
    logic signed [TERM_W-1:0] sinp;
    logic                     pos;
    logic                     neg;
  } terms_t;

endpackage

// ===== hw/rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC: four-quadrant arctangent of (y, x).
module qte_cordic import qte_pkg::*; #(
  parameter int ITERATIONS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [TERM_W-1:0] y_in,
  input  logic signed [TERM_W-1:0] x_in,
  output logic                     out_valid,
  output logic signed [ANG_W-1:0]  angle
);

  localparam int ZW = ANGLE_BITS + 2;
  localparam int SH = ANGLE_BITS - 16;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);

  logic signed [CORDIC_W-1:0] xs   [0:ITERATIONS];
  logic signed [CORDIC_W-1:0] ys   [0:ITERATIONS];
  logic signed [ZW-1:0]       zs   [0:ITERATIONS];
  logic                       zero [0:ITERATIONS];
  logic                       vld  [0:ITERATIONS];

  logic signed [CORDIC_W-1:0] xe, ye, x0, y0;
  logic signed [ZW-1:0]       z0;
  logic signed [ZW-1:0]       zf;
  logic signed [ANG_W-1:0]    ang;

  assign xe = CORDIC_W'(x_in);
  assign ye = CORDIC_W'(y_in);

  always_comb begin
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = QUARTER;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    xs[0]   <= x0;
    ys[0]   <= y0;
    zs[0]   <= z0;
    zero[0] <= (xe == 0) && (ye == 0);
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam logic [31:0] DA32 = ATAN_UNITS[i] >> (32 - ANGLE_BITS);
    localparam logic signed [ZW-1:0] DA = ZW'(DA32);
    logic signed [CORDIC_W-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (ys[i] >= 0) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + DA;
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - DA;
      end
      zero[i+1] <= zero[i];
    end
  end

  assign zf = zero[ITERATIONS] ? '0 : zs[ITERATIONS];

  if (SH > 0) begin : g_down
    localparam logic signed [ZW:0] HALF = (ZW+1)'(1) <<< (SH - 1);
    logic signed [ZW:0] zr;
    assign zr  = (ZW+1)'(zf) + HALF;
    assign ang = zr[SH+ANG_W-1:SH];
  end else if (SH < 0) begin : g_up
    assign ang = {zf, {(-SH){1'b0}}};
  end else begin : g_same
    assign ang = zf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[ITERATIONS];
    end
    angle <= ang;
  end

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Top level: quaternion in, roll, pitch and yaw binary angles out.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------
//  request   | start, busy        | quat   (quat_t, Q1.15 w,x,y,z)
//  result    | done (one cycle)   | angles (euler_t)
//
// One request per cycle; busy stays low. Latency is set by the 31-stage
// square root ahead of the pitch CORDIC and by the CORDIC stage count.
// Synchronous reset clears all valid bits. Results are never held: done
// pulses for one cycle per request.
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  quat_t  quat,
  output logic   done,
  output euler_t angles
);

  localparam int CL = CORDIC_ITERATIONS + 2;

  quat_t q1;
  logic  v1, v2, v3, v4, v5;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  terms_t t3, t3_next, t4, t5;
  logic [29:0] mag3;
  logic [59:0] msq4;
  logic signed [TERM_W-1:0] abs_sinp;

  terms_t           st  [0:ROOT_STEPS];
  logic [RAD_W-1:0] rv  [0:ROOT_STEPS];
  logic [RAD_W-1:0] res [0:ROOT_STEPS];
  logic             sv  [0:ROOT_STEPS];

  logic [1:0] fl [0:CL-1];

  logic signed [TERM_W-1:0] cx;
  logic signed [ANG_W-1:0]  roll_a, pitch_a, yaw_a;
  logic roll_v, pitch_v, yaw_v;
  euler_t angles_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    q1   <= quat;
    p_wx <= q1.quat_w * q1.quat_x;
    p_yz <= q1.quat_y * q1.quat_z;
    p_xx <= q1.quat_x * q1.quat_x;
    p_yy <= q1.quat_y * q1.quat_y;
    p_wy <= q1.quat_w * q1.quat_y;
    p_zx <= q1.quat_z * q1.quat_x;
    p_wz <= q1.quat_w * q1.quat_z;
    p_xy <= q1.quat_x * q1.quat_y;
    p_zz <= q1.quat_z * q1.quat_z;
    t3   <= t3_next;
    mag3 <= abs_sinp[29:0];
    t4   <= t3;
    msq4 <= mag3 * mag3;
    t5   <= t4;
  end

  always_comb begin
    t3_next.sinr = (TERM_W'(p_wx) + TERM_W'(p_yz)) <<< 1;
    t3_next.cosr = ONE_Q30 - ((TERM_W'(p_xx) + TERM_W'(p_yy)) <<< 1);
    t3_next.sinp = (TERM_W'(p_wy) - TERM_W'(p_zx)) <<< 1;
    t3_next.siny = (TERM_W'(p_wz) + TERM_W'(p_xy)) <<< 1;
    t3_next.cosy = ONE_Q30 - ((TERM_W'(p_yy) + TERM_W'(p_zz)) <<< 1);
    t3_next.pos  = t3_next.sinp >= ONE_Q30;
    t3_next.neg  = t3_next.sinp <= -ONE_Q30;
  end

  assign abs_sinp = (t3.sinp < 0) ? -t3.sinp : t3.sinp;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= v5;
    end
    st[0]  <= t5;
    rv[0]  <= (RAD_W'(1) << 60) - RAD_W'(msq4);
    res[0] <= '0;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (60 - 2 * k);
    logic [RAD_W-1:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= sv[k];
      end
      st[k+1] <= st[k];
      if (rv[k] >= trial) begin
        rv[k+1]  <= rv[k] - trial;
        res[k+1] <= (res[k] >> 1) + BIT;
      end else begin
        rv[k+1]  <= rv[k];
        res[k+1] <= res[k] >> 1;
      end
    end
  end

  assign cx = {3'b000, res[ROOT_STEPS][30:0]};

  qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .rst(rst), .in_valid(sv[ROOT_STEPS]),
    .y_in(st[ROOT_STEPS].sinr), .x_in(st[ROOT_STEPS].cosr),
    .out_valid(roll_v), .angle(roll_a)
  );

  qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .rst(rst), .in_valid(sv[ROOT_STEPS]),
    .y_in(st[ROOT_STEPS].sinp), .x_in(cx),
    .out_valid(pitch_v), .angle(pitch_a)
  );

  qte_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .rst(rst), .in_valid(sv[ROOT_STEPS]),
    .y_in(st[ROOT_STEPS].siny), .x_in(st[ROOT_STEPS].cosy),
    .out_valid(yaw_v), .angle(yaw_a)
  );

  always_ff @(posedge clk) begin
    fl[0] <= {st[ROOT_STEPS].pos, st[ROOT_STEPS].neg};
  end

  for (genvar j = 0; j < CL - 1; j++) begin : g_flag
    always_ff @(posedge clk) begin
      fl[j+1] <= fl[j];
    end
  end

  always_comb begin
    angles_next.roll_angle    = roll_a[15:0];
    angles_next.yaw_angle     = yaw_a[15:0];
    angles_next.pitch_clamped = fl[CL-1][1] | fl[CL-1][0];
    if (fl[CL-1][1]) begin
      angles_next.pitch_angle = PITCH_MAX[15:0];
    end else if (fl[CL-1][0]) begin
      angles_next.pitch_angle = PITCH_MIN[15:0];
    end else if (pitch_a > PITCH_MAX) begin
      angles_next.pitch_angle = PITCH_MAX[15:0];
    end else if (pitch_a < PITCH_MIN) begin
      angles_next.pitch_angle = PITCH_MIN[15:0];
    end else begin
      angles_next.pitch_angle = pitch_a[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pitch_v & roll_v & yaw_v;
    end
    angles <= angles_next;
  end

endmodule
